FILE: rtl/gdbd_pkg.sv
// Shared types, constants and calendar functions for the date-difference block.
package gdbd_pkg;

  // Field widths
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned CNT_W  = 22;
  // Serial day number of any 14-bit year fits in 23 bits
  localparam int unsigned SER_W  = 23;
  // Quotient of a 14-bit value by 100
  localparam int unsigned QUO_W  = 8;
  localparam int unsigned MUL_W  = 2 * YEAR_W;

  // Constant division by 100: multiply by the reciprocal, then shift
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [YEAR_W-1:0] RECIP_100 = YEAR_W'(10486);
  localparam logic [YEAR_W-1:0] K_100     = YEAR_W'(100);
  localparam logic [YEAR_W-1:0] K_365     = YEAR_W'(365);

  localparam int unsigned MAX_YEAR = 9999;

  // Configuration register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_COUNT_INCL = PADDR_W'(0);

  // Days from 1 January of year 0 to 1 January of year y (elaboration only)
  function automatic longint days_before_year(longint y);
    longint p;
    p = y - 1;
    if (y == 0) return 0;
    return 365 * y + 1 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint count_limit();
    longint lim;
    longint cmax;
    lim  = days_before_year(longint'(MAX_YEAR) + 1) + 1;
    cmax = (longint'(1) << CNT_W) - 1;
    return (lim < cmax) ? lim : cmax;
  endfunction

  // Largest count delivered: year range bound, clipped to the field width
  localparam logic [CNT_W+1:0] COUNT_LIMIT = (CNT_W+2)'(count_limit());

  // Days before the first of month m in a common year
  function automatic logic [8:0] month_start(logic [MON_W-1:0] m);
    logic [8:0] s;
    case (m)
      4'd1:    s = 9'd0;
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Length of month m, February stretched in leap years
  function automatic logic [DAY_W-1:0] month_len(logic [MON_W-1:0] m, logic leap);
    logic [DAY_W-1:0] l;
    case (m)
      4'd2:                     l = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  l = 5'd30;
      default:                  l = 5'd31;
    endcase
    return l;
  endfunction

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_QY,
    OP_QP,
    OP_QP4,
    OP_REM,
    OP_Y365,
    OP_DBY,
    OP_SER,
    OP_FIN
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QY,
    ST_QP,
    ST_QP4,
    ST_REM,
    ST_Y365,
    ST_DBY,
    ST_SER,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic sel;   // 0: start date, 1: end date
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

FILE: rtl/gdbd_in_if.sv
// Input channel: a pair of dates with valid/ready handshake.
interface gdbd_in_if;
  import gdbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  start_day;
  logic [MON_W-1:0]  start_month;
  logic [YEAR_W-1:0] start_year;
  logic [DAY_W-1:0]  end_day;
  logic [MON_W-1:0]  end_month;
  logic [YEAR_W-1:0] end_year;

  modport source (
    output valid, start_day, start_month, start_year, end_day, end_month, end_year,
    input  ready
  );
  modport sink (
    input  valid, start_day, start_month, start_year, end_day, end_month, end_year,
    output ready
  );
endinterface

FILE: rtl/gdbd_out_if.sv
// Output channel: day count and invalid flag with valid/ready handshake.
interface gdbd_out_if;
  import gdbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] day_count;
  logic             invalid_date;

  modport source (output valid, day_count, invalid_date, input ready);
  modport sink (input valid, day_count, invalid_date, output ready);
endinterface

FILE: rtl/gdbd_ctrl.sv
// Controller: sequences the shared multiplier steps for both dates.
module gdbd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gdbd_pkg::sts_t sts_i,
  output gdbd_pkg::cmd_t cmd_o
);
  import gdbd_pkg::*;

  state_e state_q, state_d;
  logic   sel_q, sel_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.op   = OP_NONE;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          sel_d    = 1'b0;
          state_d  = ST_QY;
        end
      end
      ST_QY: begin
        cmd_o.op = OP_QY;
        state_d  = ST_QP;
      end
      ST_QP: begin
        cmd_o.op = OP_QP;
        state_d  = ST_QP4;
      end
      ST_QP4: begin
        cmd_o.op = OP_QP4;
        state_d  = ST_REM;
      end
      ST_REM: begin
        cmd_o.op = OP_REM;
        state_d  = ST_Y365;
      end
      ST_Y365: begin
        cmd_o.op = OP_Y365;
        state_d  = ST_DBY;
      end
      ST_DBY: begin
        cmd_o.op = OP_DBY;
        state_d  = ST_SER;
      end
      ST_SER: begin
        cmd_o.op = OP_SER;
        // second pass for the end date, then finish
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_QY;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/gdbd_dp.sv
// Datapath: serial day numbers through one shared multiplier, then the difference.
module gdbd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gdbd_pkg::cmd_t                cmd_i,
  output gdbd_pkg::sts_t                sts_o,
  input  logic [gdbd_pkg::DAY_W-1:0]    start_day_i,
  input  logic [gdbd_pkg::MON_W-1:0]    start_month_i,
  input  logic [gdbd_pkg::YEAR_W-1:0]   start_year_i,
  input  logic [gdbd_pkg::DAY_W-1:0]    end_day_i,
  input  logic [gdbd_pkg::MON_W-1:0]    end_month_i,
  input  logic [gdbd_pkg::YEAR_W-1:0]   end_year_i,
  input  logic                          count_incl_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [gdbd_pkg::CNT_W-1:0]    day_count_o,
  output logic                          invalid_date_o
);
  import gdbd_pkg::*;

  // Captured dates, index 0 start, 1 end
  logic [DAY_W-1:0]  day_q  [2];
  logic [MON_W-1:0]  mon_q  [2];
  logic [YEAR_W-1:0] year_q [2];

  // Intermediate results for the date in work
  logic [QUO_W-1:0]  qy_q, qp_q, q4_q;
  logic              rem_nz_q;
  logic [SER_W-1:0]  y365_q;
  logic [SER_W-1:0]  dby_q;
  logic              leap_q;

  // Per-date results
  logic [SER_W-1:0]  ser_q [2];
  logic              ok_q  [2];

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              inv_q;

  logic [DAY_W-1:0]  d;
  logic [MON_W-1:0]  m;
  logic [YEAR_W-1:0] y, p;
  logic [YEAR_W-1:0] mul_a, mul_b;
  logic [MUL_W-1:0]  prod;
  logic              leap_d;
  logic [SER_W-1:0]  dby_d;
  logic [SER_W-1:0]  ser_d;
  logic              ok_d;
  logic [SER_W-1:0]  diff;
  logic [CNT_W+1:0]  cnt_raw;
  logic [CNT_W+1:0]  cnt_sat;

  assign d = day_q[cmd_i.sel];
  assign m = mon_q[cmd_i.sel];
  assign y = year_q[cmd_i.sel];
  assign p = y - YEAR_W'(1);

  // Shared multiplier operand select
  always_comb begin
    mul_a = y;
    mul_b = RECIP_100;
    case (cmd_i.op)
      OP_QP:   mul_a = p;
      OP_QP4:  mul_a = {2'b00, p[YEAR_W-1:2]};
      OP_REM: begin
        mul_a = {{(YEAR_W-QUO_W){1'b0}}, qy_q};
        mul_b = K_100;
      end
      OP_Y365: mul_b = K_365;
      default: mul_b = RECIP_100;
    endcase
  end
  assign prod = mul_a * mul_b;

  // Leap year: divisible by 4 and not by 100, or by 400 (quotient by 100 divisible by 4)
  assign leap_d = (y[1:0] == 2'b00 && rem_nz_q) || (!rem_nz_q && qy_q[1:0] == 2'b00);

  // Days before the year; year 0 starts the count
  assign dby_d = (y == '0) ? '0 :
                 y365_q + SER_W'(1) + SER_W'(p[YEAR_W-1:2]) - SER_W'(qp_q) + SER_W'(q4_q);

  // Serial day and range check of the date
  assign ok_d  = (m >= 4'd1) && (m <= 4'd12) && (d != '0) && (d <= month_len(m, leap_q));
  assign ser_d = dby_q + SER_W'(month_start(m)) + SER_W'(d) - SER_W'(1)
                 + SER_W'((m > 4'd2) && leap_q);

  // Difference, inclusive adjust and saturation
  assign diff    = (ser_q[0] < ser_q[1]) ? (ser_q[1] - ser_q[0]) : '0;
  assign cnt_raw = (CNT_W+2)'(diff) + (CNT_W+2)'(count_incl_i);
  assign cnt_sat = (cnt_raw > COUNT_LIMIT) ? COUNT_LIMIT : cnt_raw;

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        day_q[0]  <= start_day_i;
        mon_q[0]  <= start_month_i;
        year_q[0] <= start_year_i;
        day_q[1]  <= end_day_i;
        mon_q[1]  <= end_month_i;
        year_q[1] <= end_year_i;
      end
      OP_QY:   qy_q     <= prod[RECIP_SHIFT +: QUO_W];
      OP_QP:   qp_q     <= prod[RECIP_SHIFT +: QUO_W];
      OP_QP4:  q4_q     <= prod[RECIP_SHIFT +: QUO_W];
      OP_REM:  rem_nz_q <= (prod[YEAR_W-1:0] != y);
      OP_Y365: y365_q   <= prod[SER_W-1:0];
      OP_DBY: begin
        dby_q  <= dby_d;
        leap_q <= leap_d;
      end
      OP_SER: begin
        ser_q[cmd_i.sel] <= ser_d;
        ok_q[cmd_i.sel]  <= ok_d;
      end
      OP_FIN: begin
        if (ok_q[0] && ok_q[1]) begin
          cnt_q <= cnt_sat[CNT_W-1:0];
          inv_q <= 1'b0;
        end else begin
          cnt_q <= '0;
          inv_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output word valid: set on finish, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.op == OP_FIN) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.out_busy = out_valid_q;
  assign out_valid_o    = out_valid_q;
  assign day_count_o    = cnt_q;
  assign invalid_date_o = inv_q;

endmodule

FILE: rtl/gregorian_days_between_dates.sv
// Top level of the Gregorian days-between-dates block.
// Takes a word of two dates and returns the days from the first to the second
// (0 when the first is not earlier, plus one when count_inclusive is set),
// or invalid_date with a count of 0 when a day or month is out of range.
// Counts are clipped to the days in years 0..MAX_YEAR plus one. Each date is
// turned into a serial day number by a fixed sequence of seven steps through a
// single shared 14x14 multiplier (divisions by 100 by reciprocal, remainder,
// times 365, then two adds); the result register is loaded once both dates are
// through and the output register is free, and a new word is accepted only
// after the last one has been loaded into it. A result waiting in the output
// register does not stop the next word from being accepted.
// count_inclusive sits at byte address 0 of the APB port.
module gregorian_days_between_dates (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gdbd_in_if.sink                        in_i,
  gdbd_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gdbd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import gdbd_pkg::*;

  logic count_incl_q;
  cmd_t cmd;
  sts_t sts;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_incl_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_COUNT_INCL) begin
      count_incl_q <= pwdata[0];
    end
  end

  assign prdata = (paddr == ADDR_COUNT_INCL) ? {31'd0, count_incl_q} : 32'd0;

  gdbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gdbd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .start_day_i    (in_i.start_day),
    .start_month_i  (in_i.start_month),
    .start_year_i   (in_i.start_year),
    .end_day_i      (in_i.end_day),
    .end_month_i    (in_i.end_month),
    .end_year_i     (in_i.end_year),
    .count_incl_i   (count_incl_q),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .day_count_o    (out_o.day_count),
    .invalid_date_o (out_o.invalid_date)
  );

endmodule

FILE: rtl/gdbd_checker.sv
// Port-level checks for the days-between-dates block, bound to the top level.
module gdbd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [gdbd_pkg::CNT_W-1:0]  day_count_i,
  input logic                        invalid_date_i
);
  import gdbd_pkg::*;

  // One word in work at a time: no word is taken right after another
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken again right after an accept");

  // Invalid dates carry a zero count
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && invalid_date_i) |-> (day_count_i == '0))
    else $error("invalid date with nonzero count");

  // Count never above the year-range limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((CNT_W+2)'(day_count_i) <= COUNT_LIMIT))
    else $error("count above limit");

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(day_count_i) && $stable(invalid_date_i)))
    else $error("stalled result changed");

endmodule

bind gregorian_days_between_dates gdbd_checker u_gdbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .day_count_i    (out_o.day_count),
  .invalid_date_i (out_o.invalid_date)
);
